/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Geometry, codes, the command word passed from front to back, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int LAST_BASE = CELLS - COLUMNS;

    // row of a cell index: (index * ROW_RECIP) >> ROW_SHIFT, exact below CELLS
    localparam int ROW_SHIFT  = 17;
    localparam int ROW_RECIP  = ((1 << ROW_SHIFT) + COLUMNS - 1) / COLUMNS;
    localparam int DIV_PROD_W = ROW_SHIFT + ROW_W;

    // port field widths
    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 16;
    localparam int CURSOR_W  = 11;
    localparam int COLOR_W   = 4;
    localparam int CELL_W    = 16;
    localparam int IN_DATA_W = 24;
    localparam int OUT_W     = 32;
    localparam int OUT_PAD   = OUT_W - CURSOR_W - 2 * CHAR_W;
    localparam int CFG_IDX_W = 2;

    // short command queue
    localparam int Q_DEPTH   = 2;
    localparam int Q_IDX_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_SPACE = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;
    localparam logic [CELL_W-1:0]  RESET_BLANK = {RESET_FG, RESET_BG, CH_SPACE};

    localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_BACKSPACE  = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_PUT_HEX    = 3'd3,
        OP_SET_CURSOR = 3'd4,
        OP_READ_CELL  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        K_CHAR  = 3'd0,
        K_BS    = 3'd1,
        K_CLEAR = 3'd2,
        K_SET   = 3'd3,
        K_READ  = 3'd4,
        K_NOP   = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  chr0;
        logic [CHAR_W-1:0]  chr1;
        logic               two;   // a second character follows chr0
        logic [ADDR_W-1:0]  pos;   // clamped cell index
    } cmd_t;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] d;
        if (v < 4'd10) begin
            d = 8'h30 + {4'h0, v};
        end else begin
            d = 8'h37 + {4'h0, v};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front: input decode stage
// Accepts stream transfers, decodes the operation, clamps the position and
// expands a hex byte into two digit characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            init_busy,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire  [tcw_pkg::OP_W-1:0]       s_tuser,
    output logic                           push_valid,
    input  wire                            push_ready,
    output tcw_pkg::cmd_t                  push_cmd
);
    import tcw_pkg::*;

    logic              valid_reg, valid_next;
    cmd_t              cmd_reg, cmd_next;
    cmd_t              dec;
    logic [CHAR_W-1:0] code;
    logic [POS_W-1:0]  pos;
    logic              accept;

    assign code = s_tdata[CHAR_W-1:0];
    assign pos  = s_tdata[CHAR_W +: POS_W];

    always_comb begin
        dec.chr0 = code;
        dec.chr1 = hex_digit(code[3:0]);
        dec.two  = 1'b0;
        dec.pos  = (pos > POS_W'(CELLS - 1)) ? ADDR_W'(CELLS - 1) : pos[ADDR_W-1:0];
        unique case (s_tuser)
            OP_PUT_CHAR:   dec.kind = K_CHAR;
            OP_BACKSPACE:  dec.kind = K_BS;
            OP_CLEAR:      dec.kind = K_CLEAR;
            OP_PUT_HEX: begin
                dec.kind = K_CHAR;
                dec.chr0 = hex_digit(code[7:4]);
                dec.two  = 1'b1;
            end
            OP_SET_CURSOR: dec.kind = K_SET;
            OP_READ_CELL:  dec.kind = K_READ;
            default:       dec.kind = K_NOP;
        endcase
    end

    assign s_tready   = !init_busy && (!valid_reg || push_ready);
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept) begin
            valid_next = 1'b1;
            cmd_next   = dec;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

/* rtl/tcw_queue.sv */
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// Two-entry FIFO between the decode front and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            push_valid,
    output logic           push_ready,
    input  tcw_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  wire            pop,
    output tcw_pkg::cmd_t  pop_cmd
);
    import tcw_pkg::*;

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back: execution engine
// Owns the cell memory, the cursor and the result register; runs one command
// at a time, including the scroll and clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  [tcw_pkg::CHAR_W-1:0]    attr,
    input  wire                           cmd_valid,
    output logic                          cmd_pop,
    input  tcw_pkg::cmd_t                 cmd,
    output logic                          init_busy,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [tcw_pkg::OUT_W-1:0]     m_tdata
);
    import tcw_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHAR   = 7'b0000010,
        S_SCROLL = 7'b0000100,
        S_FILL   = 7'b0001000,
        S_DIVIDE = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  scan_reg, scan_next;
    logic [ADDR_W-1:0]  rem_reg, rem_next;
    logic               sc_wvalid_reg, sc_wvalid_next;
    logic [ADDR_W-1:0]  sc_waddr_reg, sc_waddr_next;
    logic [CELL_W-1:0]  blank_reg, blank_next;
    logic [CHAR_W-1:0]  chr_reg, chr_next;
    logic [CHAR_W-1:0]  chr2_reg, chr2_next;
    logic               two_reg, two_next;
    logic               init_reg, init_next;
    logic [CHAR_W-1:0]  rchar_reg, rchar_next;
    logic [CHAR_W-1:0]  rattr_reg, rattr_next;
    logic               mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]   mdata_reg, mdata_next;

    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  cursor;
    logic               sweep_done;

    logic [DIV_PROD_W-1:0] row_prod;
    logic [ROW_W-1:0]      row_idx;
    logic [ADDR_W-1:0]     row_base;
    logic [ADDR_W-1:0]     col_rem;

    assign cursor    = base_reg + ADDR_W'(col_reg);
    assign init_busy = init_reg;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign rd_addr   = (state_reg == S_SCROLL) ? scan_reg + ADDR_W'(COLUMNS) : cmd.pos;

    // split a cell index into row base and column by reciprocal multiply
    assign row_prod = DIV_PROD_W'(rem_reg) * DIV_PROD_W'(ROW_RECIP);
    assign row_idx  = row_prod[ROW_SHIFT +: ROW_W];
    assign row_base = ADDR_W'(row_idx) * ADDR_W'(COLUMNS);
    assign col_rem  = rem_reg - row_base;

    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        scan_next      = scan_reg;
        rem_next       = rem_reg;
        sc_wvalid_next = 1'b0;
        sc_waddr_next  = sc_waddr_reg;
        blank_next     = blank_reg;
        chr_next       = chr_reg;
        chr2_next      = chr2_reg;
        two_next       = two_reg;
        init_next      = init_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        mvalid_next    = mvalid_reg && !m_tready;
        mdata_next     = mdata_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cursor;
        wr_data        = {attr, chr_reg};
        sweep_done     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    rchar_next = '0;
                    rattr_next = '0;
                    chr_next   = cmd.chr0;
                    chr2_next  = cmd.chr1;
                    two_next   = cmd.two;
                    case (cmd.kind)
                        K_CHAR: state_next = S_CHAR;
                        K_BS: begin
                            if (cursor != '0) begin
                                wr_en   = 1'b1;
                                wr_addr = cursor - 1'b1;
                                wr_data = {attr, CH_SPACE};
                                if (col_reg == '0) begin
                                    base_next = base_reg - ADDR_W'(COLUMNS);
                                    col_next  = COL_W'(COLUMNS - 1);
                                end else begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            state_next = S_RESULT;
                        end
                        K_CLEAR: begin
                            base_next  = '0;
                            col_next   = '0;
                            scan_next  = '0;
                            blank_next = {attr, CH_SPACE};
                            state_next = S_FILL;
                        end
                        K_SET: begin
                            rem_next   = cmd.pos;
                            state_next = S_DIVIDE;
                        end
                        K_READ:  state_next = S_READ;
                        default: state_next = S_RESULT;
                    endcase
                end
            end

            S_CHAR: begin
                if (chr_reg == CH_LF) begin
                    col_next = '0;
                    if (base_reg == ADDR_W'(LAST_BASE)) begin
                        scan_next  = '0;
                        blank_next = {attr, CH_SPACE};
                        state_next = S_SCROLL;
                    end else begin
                        base_next = base_reg + ADDR_W'(COLUMNS);
                    end
                end else if (chr_reg == CH_CR) begin
                    col_next = '0;
                end else if (cursor == ADDR_W'(CELLS - 1)) begin
                    // a character aimed at the last cell is not written: the whole screen is wiped
                    base_next  = '0;
                    col_next   = '0;
                    scan_next  = '0;
                    blank_next = {attr, CH_SPACE};
                    state_next = S_FILL;
                end else begin
                    wr_en = 1'b1;
                    if (col_reg == COL_W'(COLUMNS - 1)) begin
                        col_next  = '0;
                        base_next = base_reg + ADDR_W'(COLUMNS);
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
                if (state_next == S_CHAR) begin
                    if (two_reg) begin
                        chr_next = chr2_reg;
                        two_next = 1'b0;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_SCROLL: begin
                // copy one row down in the address space: read ahead, write behind
                wr_en   = sc_wvalid_reg;
                wr_addr = sc_waddr_reg;
                wr_data = rd_data_reg;
                if (scan_reg != ADDR_W'(LAST_BASE)) begin
                    sc_wvalid_next = 1'b1;
                    sc_waddr_next  = scan_reg;
                    scan_next      = scan_reg + 1'b1;
                end else begin
                    state_next = S_FILL;
                end
            end

            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = scan_reg;
                wr_data = blank_reg;
                if (scan_reg == ADDR_W'(CELLS - 1)) begin
                    sweep_done = 1'b1;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_DIVIDE: begin
                base_next  = row_base;
                col_next   = col_rem[COL_W-1:0];
                state_next = S_RESULT;
            end

            S_READ: begin
                rchar_next = rd_data_reg[CHAR_W-1:0];
                rattr_next = rd_data_reg[CELL_W-1:CHAR_W];
                state_next = S_RESULT;
            end

            S_RESULT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {{OUT_PAD{1'b0}}, rattr_reg, rchar_reg, CURSOR_W'(cursor)};
                    state_next  = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (sweep_done) begin
            init_next = 1'b0;
            if (two_reg) begin
                chr_next   = chr2_reg;
                two_next   = 1'b0;
                state_next = S_CHAR;
            end else if (init_reg) begin
                state_next = S_IDLE;
            end else begin
                state_next = S_RESULT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            base_reg      <= '0;
            col_reg       <= '0;
            scan_reg      <= '0;
            sc_wvalid_reg <= 1'b0;
            blank_reg     <= RESET_BLANK;
            two_reg       <= 1'b0;
            init_reg      <= 1'b1;
            mvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            col_reg       <= col_next;
            scan_reg      <= scan_next;
            sc_wvalid_reg <= sc_wvalid_next;
            blank_reg     <= blank_next;
            two_reg       <= two_next;
            init_reg      <= init_next;
            mvalid_reg    <= mvalid_next;
        end
        rem_reg      <= rem_next;
        sc_waddr_reg <= sc_waddr_next;
        chr_reg      <= chr_next;
        chr2_reg     <= chr2_next;
        rchar_reg    <= rchar_next;
        rattr_reg    <= rattr_next;
        mdata_reg    <= mdata_next;
    end

endmodule

`default_nettype wire

/* rtl/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit: 80x25 character-cell text console
// Cell store with cursor; put char, backspace, clear, put hex, set cursor
// and read cell, one result transfer per command.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the 2000-cell store to blanks (space, attribute
// 0xF0), one cell per cycle, so s_tready stays low until the sweep is done;
// configuration writes are taken during that time. A decode front end takes
// one command per cycle while the queue has room into a two-entry queue, and
// an execution engine that owns the cell memory works through them one at a
// time. Engine steps: a plain, carriage return or line feed character, read
// cell and set cursor go through dispatch, action and result; backspace and
// unused codes through dispatch with action, then result; put hex repeats
// the action for its second digit. The row of a set cursor comes from a
// combinational reciprocal multiply. Clear and a character in the last cell
// run a blanking sweep of all 2000 cells over the memory's single write
// port; a bottom-row line feed shifts the lower 24 rows (1920 cells) up one
// row, then blanks the last row's 80 cells. The result sits in an output
// register, so the front end keeps accepting while a result waits on m_tready.
// Colors are written via the cfg port (index 0 foreground, 1 background;
// others dropped) only while idle: a user rule the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    // command stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [tcw_pkg::IN_DATA_W-1:0]    s_tdata,  // char_code[7:0], position[23:8]
    input  wire  [tcw_pkg::OP_W-1:0]         s_tuser,  // operation[2:0]
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [tcw_pkg::OUT_W-1:0]        m_tdata,  // cursor_position[10:0],
                                                       // cell_char[18:11],
                                                       // cell_attribute[26:19], zero
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tcw_pkg::COLOR_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic               init_busy;
    logic               push_valid, push_ready;
    cmd_t               push_cmd;
    logic               q_valid, q_pop;
    cmd_t               q_cmd;

    // color registers: take every write, drop unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FG:  fg_reg <= cfg_data;
                REG_BG:  bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode: operation to command, clamp position, expand hex digits
    tcw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init_busy  (init_busy),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouple decode from the long-running sweeps of the engine
    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // engine: cell memory, cursor, result register
    tcw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .attr      ({fg_reg, bg_reg}),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tready,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire  [tcw_pkg::OUT_W-1:0]        m_tdata
);
    import tcw_pkg::*;

    // a held result transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the reported cursor always lies on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CURSOR_W-1:0] <= CURSOR_W'(CELLS - 1))
        else $error("cursor out of range");

    // the store is being blanked right after reset: no commands taken
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("command accepted during reset sweep");

    // no result appears out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the padding above the attribute stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:OUT_W-OUT_PAD] == '0)
        else $error("nonzero padding in result");

endmodule

bind text_console_writer_unit tcw_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
